>>> rtl/gdrc_pkg.sv
// shared types and constants of the grid ray caster
package gdrc_pkg;

  localparam int DIST_W = 20;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  localparam int DIV_N_W = 48;
  localparam int DIV_D_W = 32;
  localparam int ROOT_W = 24;

  // which scaled length the setup loop is working on
  localparam logic [1:0] LEN_DLX = 2'd0;
  localparam logic [1:0] LEN_DLY = 2'd1;
  localparam logic [1:0] LEN_SDX = 2'd2;
  localparam logic [1:0] LEN_SDY = 2'd3;

  // register indexes on the configuration port
  localparam logic REG_CELL_WIDTH = 1'b0;
  localparam logic REG_CELL_HEIGHT = 1'b1;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_M2,
    ST_MODX,
    ST_MODXW,
    ST_MODY,
    ST_MODYW,
    ST_LEN,
    ST_KK,
    ST_NUM,
    ST_DIV,
    ST_DIVW,
    ST_SQRTW,
    ST_RD,
    ST_TEST,
    ST_DONE
  } state_t;

  // handshake between the sequencer and an iterative unit
  typedef struct packed {
    logic start;
  } unit_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

endpackage

>>> rtl/grid_dda_ray_caster.sv
// grid ray caster top level: sequencer, shared multiplier, wall map and walk
// a map write is done at acceptance; a cast squares the direction, does two divides for the
// offsets in the start cell, then multiplies, a divide and a square root per scaled length with a
// nonzero component (a zero one is set to the maximum), reads the wall map once per cell visited
// and loads the result; one item at a time, the next accepted once the result is in the
// output register; rst is synchronous, then a pass clears every map cell, no item accepted
module grid_dda_ray_caster #(
  parameter int MAP_COLS = 32,
  parameter int MAP_ROWS = 32,
  parameter int MAX_STEPS = 64
) (
  input  logic        clk,
  input  logic        rst,
  // apb configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input items
  input  logic        s_tvalid,
  output logic        s_tready,
  // map_index[9:0] wall_bit[10] pos_x[26:11] pos_y[42:27] start_col[47:43]
  // start_row[52:48] dir_x[68:53] dir_y[84:69] zero[87:85]
  input  logic [87:0] s_tdata,
  // op[0]
  input  logic        s_tuser,
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  // hit[0] hit_col[5:1] hit_row[10:6] hit_distance[30:11] crossed_x_side[31]
  output logic [31:0] m_tdata
);
  import gdrc_pkg::*;

  localparam int CELLS = MAP_COLS * MAP_ROWS;
  localparam int AW = $clog2(CELLS);
  localparam int CW = $clog2(MAP_COLS);
  localparam int RW = $clog2(MAP_ROWS);
  localparam int SW = $clog2(MAX_STEPS + 1);
  localparam logic [CW-1:0] COL_LAST = CW'(MAP_COLS - 1);
  localparam logic [RW-1:0] ROW_LAST = RW'(MAP_ROWS - 1);
  localparam logic [AW-1:0] CLR_LAST = AW'(CELLS - 1);

  // input fields
  logic        in_op;
  logic [9:0]  in_map_index;
  logic        in_wall_bit;
  logic [15:0] in_pos_x;
  logic [15:0] in_pos_y;
  logic [4:0]  in_start_col;
  logic [4:0]  in_start_row;
  logic [15:0] in_dir_x;
  logic [15:0] in_dir_y;

  assign in_op = s_tuser;
  assign in_map_index = s_tdata[9:0];
  assign in_wall_bit = s_tdata[10];
  assign in_pos_x = s_tdata[26:11];
  assign in_pos_y = s_tdata[42:27];
  assign in_start_col = s_tdata[47:43];
  assign in_start_row = s_tdata[52:48];
  assign in_dir_x = s_tdata[68:53];
  assign in_dir_y = s_tdata[84:69];

  state_t state, state_next;

  logic [7:0]  cell_width;
  logic [7:0]  cell_height;
  logic [7:0]  wdata8;

  // cast registers
  logic [15:0] px, py;
  logic [15:0] ax, ay;
  logic        negx, negy;
  logic        in_range;
  logic [4:0]  start_col_q, start_row_q;
  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic [31:0] m2;
  logic [7:0]  sx, sy;
  logic [47:0] prod;
  logic [47:0] num;
  logic [1:0]  len_sel;
  logic [DIST_W-1:0] dlx, dly, sdx, sdy;
  logic [DIST_W-1:0] lastx, lasty;
  logic        anyx, anyy;
  logic        hit_q;
  logic [SW-1:0] steps;
  logic [AW-1:0] clr_cnt;

  // shared multiplier operands
  logic [31:0] mul_a;
  logic [15:0] mul_b;
  logic [47:0] mul_p;

  // iterative units
  unit_ctl_t div_ctl, sqrt_ctl;
  unit_sts_t div_sts, sqrt_sts;
  logic [DIV_N_W-1:0] div_dividend;
  logic [DIV_D_W-1:0] div_divisor;
  logic [DIV_N_W-1:0] div_quot;
  logic [DIV_D_W-1:0] div_rem;
  logic [ROOT_W-1:0]  sqrt_root;

  // wall map
  logic          map [CELLS];
  logic          map_we;
  logic [AW-1:0] map_waddr;
  logic          map_wbit;
  logic [AW-1:0] map_raddr;
  logic          map_rbit;
  logic [31:0]   raddr_full;
  logic [31:0]   widx_ext;
  logic          widx_ok;

  // length loop selection
  logic [7:0]  len_k;
  logic [15:0] len_a;
  logic [DIST_W-1:0] root_sat;

  // walk decisions
  logic stepx, leaves, walk_stop;
  logic [DIST_W:0] sumx, sumy;
  logic [DIST_W-1:0] nsdx, nsdy;

  // result
  logic [DIST_W-1:0] res_dist;
  logic        res_side;
  logic [4:0]  res_col, res_row;
  logic [31:0] col_ext, row_ext;
  logic [31:0] scol_ext, srow_ext;
  logic        in_start_ok;

  logic s_acc, cfg_wr;

  assign s_acc = s_tvalid && s_tready;
  assign cfg_wr = psel && penable && pwrite && pready;

  // configuration registers
  assign pready = 1'b1;
  assign wdata8 = (pwdata[7:0] == 8'd0) ? 8'd1 : pwdata[7:0];
  assign prdata = (paddr[2] == REG_CELL_HEIGHT) ? {24'd0, cell_height} : {24'd0, cell_width};

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_width <= 8'd64;
      cell_height <= 8'd64;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_CELL_WIDTH) begin
        cell_width <= wdata8;
      end else begin
        cell_height <= wdata8;
      end
    end
  end

  // operand selection for the current scaled length
  always_comb begin
    case (len_sel)
      LEN_DLX: begin
        len_k = cell_width;
        len_a = ax;
      end
      LEN_DLY: begin
        len_k = cell_height;
        len_a = ay;
      end
      LEN_SDX: begin
        len_k = sx;
        len_a = ax;
      end
      LEN_SDY: begin
        len_k = sy;
        len_a = ay;
      end
      default: begin
        len_k = cell_width;
        len_a = ax;
      end
    endcase
  end

  assign root_sat = (sqrt_root > ROOT_W'(DIST_MAX)) ? DIST_MAX : sqrt_root[DIST_W-1:0];

  // shared multiplier, result registered in prod
  assign mul_p = mul_a * mul_b;

  // map addressing
  assign raddr_full = 32'(row) * 32'(MAP_COLS) + 32'(col);
  assign map_raddr = raddr_full[AW-1:0];
  assign widx_ext = 32'(in_map_index);
  assign widx_ok = widx_ext < 32'(CELLS);
  assign scol_ext = 32'(in_start_col);
  assign srow_ext = 32'(in_start_row);
  assign in_start_ok = (scol_ext < 32'(MAP_COLS)) && (srow_ext < 32'(MAP_ROWS));

  always_ff @(posedge clk) begin
    if (map_we) begin
      map[map_waddr] <= map_wbit;
    end
    map_rbit <= map[map_raddr];
  end

  // walk step decision
  always_comb begin
    stepx = (ax != 16'd0) && ((ay == 16'd0) || (sdx <= sdy));
    if (stepx) begin
      leaves = negx ? (col == '0) : (col == COL_LAST);
    end else begin
      leaves = negy ? (row == '0) : (row == ROW_LAST);
    end
    walk_stop = map_rbit || (steps >= SW'(MAX_STEPS)) ||
                ((ax == 16'd0) && (ay == 16'd0)) || leaves;
    sumx = {1'b0, sdx} + {1'b0, dlx};
    sumy = {1'b0, sdy} + {1'b0, dly};
    nsdx = sumx[DIST_W] ? DIST_MAX : sumx[DIST_W-1:0];
    nsdy = sumy[DIST_W] ? DIST_MAX : sumy[DIST_W-1:0];
  end

  // result selection
  always_comb begin
    col_ext = 32'(col);
    row_ext = 32'(row);
    res_col = in_range ? col_ext[4:0] : start_col_q;
    res_row = in_range ? row_ext[4:0] : start_row_q;
    if (anyx && (!anyy || (lastx > lasty))) begin
      res_dist = lastx;
      res_side = 1'b1;
    end else if (anyy) begin
      res_dist = lasty;
      res_side = 1'b0;
    end else begin
      res_dist = '0;
      res_side = 1'b0;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_cnt == CLR_LAST) state_next = ST_IDLE;
      ST_IDLE: begin
        if (s_acc && in_op) begin
          state_next = in_start_ok ? ST_SQX : ST_DONE;
        end
      end
      ST_SQX: state_next = ST_SQY;
      ST_SQY: state_next = ST_M2;
      ST_M2: state_next = ST_MODX;
      ST_MODX: state_next = ST_MODXW;
      ST_MODXW: if (div_sts.done) state_next = ST_MODY;
      ST_MODY: state_next = ST_MODYW;
      ST_MODYW: if (div_sts.done) state_next = ST_LEN;
      ST_LEN: begin
        if (len_a != 16'd0) begin
          state_next = ST_KK;
        end else if (len_sel == LEN_SDY) begin
          state_next = ST_RD;
        end
      end
      ST_KK: state_next = ST_NUM;
      ST_NUM: state_next = ST_DIV;
      ST_DIV: state_next = ST_DIVW;
      ST_DIVW: if (div_sts.done) state_next = ST_SQRTW;
      ST_SQRTW: begin
        if (sqrt_sts.done) begin
          state_next = (len_sel == LEN_SDY) ? ST_RD : ST_LEN;
        end
      end
      ST_RD: state_next = ST_TEST;
      ST_TEST: state_next = walk_stop ? ST_DONE : ST_RD;
      ST_DONE: if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_tready = 1'b0;
    div_ctl.start = 1'b0;
    sqrt_ctl.start = 1'b0;
    div_dividend = 48'(px);
    div_divisor = 32'(cell_width);
    mul_a = 32'(ax);
    mul_b = ax;
    map_we = 1'b0;
    map_waddr = clr_cnt;
    map_wbit = 1'b0;
    case (state)
      ST_CLEAR: begin
        map_we = 1'b1;
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        map_waddr = widx_ext[AW-1:0];
        map_wbit = in_wall_bit;
        map_we = s_acc && !in_op && widx_ok;
      end
      ST_SQY: begin
        mul_a = 32'(ay);
        mul_b = ay;
      end
      ST_MODX: begin
        div_ctl.start = 1'b1;
      end
      ST_MODY: begin
        div_ctl.start = 1'b1;
        div_dividend = 48'(py);
        div_divisor = 32'(cell_height);
      end
      ST_LEN: begin
        mul_a = 32'(len_k);
        mul_b = 16'(len_k);
      end
      ST_KK: begin
        mul_a = m2;
        mul_b = prod[15:0];
      end
      ST_NUM: begin
        mul_a = 32'(len_a);
        mul_b = len_a;
      end
      ST_DIV: begin
        div_ctl.start = 1'b1;
        div_dividend = num;
        div_divisor = prod[31:0];
      end
      ST_DIVW: begin
        sqrt_ctl.start = div_sts.done;
      end
      default: begin
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_cnt <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (state == ST_DONE && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // cast datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (s_acc && in_op) begin
          px <= in_pos_x;
          py <= in_pos_y;
          negx <= in_dir_x[15];
          negy <= in_dir_y[15];
          ax <= in_dir_x[15] ? (16'd0 - in_dir_x) : in_dir_x;
          ay <= in_dir_y[15] ? (16'd0 - in_dir_y) : in_dir_y;
          start_col_q <= in_start_col;
          start_row_q <= in_start_row;
          col <= scol_ext[CW-1:0];
          row <= srow_ext[RW-1:0];
          in_range <= in_start_ok;
          anyx <= 1'b0;
          anyy <= 1'b0;
          lastx <= '0;
          lasty <= '0;
          hit_q <= 1'b0;
          steps <= '0;
          len_sel <= LEN_DLX;
        end
      end
      ST_SQX: prod <= mul_p;
      ST_SQY: begin
        m2 <= prod[31:0];
        prod <= mul_p;
      end
      ST_M2: m2 <= m2 + prod[31:0];
      ST_MODXW: begin
        if (div_sts.done) begin
          sx <= negx ? div_rem[7:0] : (cell_width - div_rem[7:0]);
        end
      end
      ST_MODYW: begin
        if (div_sts.done) begin
          sy <= negy ? div_rem[7:0] : (cell_height - div_rem[7:0]);
        end
      end
      ST_LEN: begin
        prod <= mul_p;
        if (len_a == 16'd0) begin
          case (len_sel)
            LEN_DLX: dlx <= DIST_MAX;
            LEN_DLY: dly <= DIST_MAX;
            LEN_SDX: sdx <= DIST_MAX;
            default: sdy <= DIST_MAX;
          endcase
          len_sel <= len_sel + 1'b1;
        end
      end
      ST_KK: prod <= mul_p;
      ST_NUM: begin
        num <= prod;
        prod <= mul_p;
      end
      ST_SQRTW: begin
        if (sqrt_sts.done) begin
          case (len_sel)
            LEN_DLX: dlx <= root_sat;
            LEN_DLY: dly <= root_sat;
            LEN_SDX: sdx <= root_sat;
            default: sdy <= root_sat;
          endcase
          len_sel <= len_sel + 1'b1;
        end
      end
      ST_TEST: begin
        if (map_rbit) begin
          hit_q <= 1'b1;
        end else if (!walk_stop) begin
          steps <= steps + 1'b1;
          if (stepx) begin
            col <= negx ? (col - 1'b1) : (col + 1'b1);
            lastx <= sdx;
            anyx <= 1'b1;
            sdx <= nsdx;
          end else begin
            row <= negy ? (row - 1'b1) : (row + 1'b1);
            lasty <= sdy;
            anyy <= 1'b1;
            sdy <= nsdy;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!m_tvalid || m_tready)) begin
      m_tdata <= {res_side, res_dist, res_row, res_col, hit_q};
    end
  end

  gdrc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl      (div_ctl),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .sts      (div_sts),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  gdrc_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .ctl   (sqrt_ctl),
    .value (div_quot),
    .sts   (sqrt_sts),
    .root  (sqrt_root)
  );

`ifndef SYNTH
  a_steps_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RD || state == ST_TEST) |-> (steps <= SW'(MAX_STEPS)))
    else $error("step count beyond limit");

  a_walk_in_map: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TEST) |-> ((32'(col) < 32'(MAP_COLS)) && (32'(row) < 32'(MAP_ROWS))))
    else $error("walk left the map");

  a_div_done_expected: assert property (@(posedge clk) disable iff (rst)
    div_sts.done |-> (state == ST_MODXW || state == ST_MODYW || state == ST_DIVW))
    else $error("divider finished outside a wait state");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == ST_DONE))
    else $error("result loaded outside done state");
`endif

endmodule

>>> rtl/gdrc_div.sv
// iterative restoring divider, one quotient bit per cycle
module gdrc_div (
  input  logic                           clk,
  input  logic                           rst,
  input  gdrc_pkg::unit_ctl_t            ctl,
  input  logic [gdrc_pkg::DIV_N_W-1:0]   dividend,
  input  logic [gdrc_pkg::DIV_D_W-1:0]   divisor,
  output gdrc_pkg::unit_sts_t            sts,
  output logic [gdrc_pkg::DIV_N_W-1:0]   quot,
  output logic [gdrc_pkg::DIV_D_W-1:0]   rem
);
  import gdrc_pkg::*;

  localparam int CNT_W = $clog2(DIV_N_W + 1);

  logic [CNT_W-1:0]   cnt;
  logic [DIV_D_W-1:0] dvs;
  logic [DIV_D_W:0]   shifted;
  logic [DIV_D_W:0]   diff;
  logic               busy;
  logic               done;

  // trial subtract of the divisor from the shifted remainder
  always_comb begin
    shifted = {rem, quot[DIV_N_W-1]};
    diff = shifted - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt <= CNT_W'(DIV_N_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      quot <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      if (!diff[DIV_D_W]) begin
        rem <= diff[DIV_D_W-1:0];
        quot <= {quot[DIV_N_W-2:0], 1'b1};
      end else begin
        rem <= shifted[DIV_D_W-1:0];
        quot <= {quot[DIV_N_W-2:0], 1'b0};
      end
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;

endmodule

>>> rtl/gdrc_sqrt.sv
// iterative integer square root, one root bit per cycle
module gdrc_sqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  gdrc_pkg::unit_ctl_t           ctl,
  input  logic [gdrc_pkg::DIV_N_W-1:0]  value,
  output gdrc_pkg::unit_sts_t           sts,
  output logic [gdrc_pkg::ROOT_W-1:0]   root
);
  import gdrc_pkg::*;

  localparam int CNT_W = $clog2(ROOT_W + 1);
  localparam int REM_W = ROOT_W + 2;

  logic [CNT_W-1:0]   cnt;
  logic [DIV_N_W-1:0] src;
  logic [REM_W-1:0]   rem;
  logic [REM_W+1:0]   rem2;
  logic [REM_W+1:0]   trial;
  logic [REM_W+1:0]   diff;
  logic               busy;
  logic               done;

  // bring down two bits and try the next root bit
  always_comb begin
    rem2 = {rem, src[DIV_N_W-1 -: 2]};
    trial = {2'b00, root, 2'b01};
    diff = rem2 - trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt <= CNT_W'(ROOT_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      src <= value;
      rem <= '0;
      root <= '0;
    end else if (busy) begin
      src <= {src[DIV_N_W-3:0], 2'b00};
      if (rem2 >= trial) begin
        rem <= diff[REM_W-1:0];
        root <= {root[ROOT_W-2:0], 1'b1};
      end else begin
        rem <= rem2[REM_W-1:0];
        root <= {root[ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;

endmodule

>>> verif/tb_grid_dda_ray_caster.sv
// testbench of the grid ray caster: random walls and casts, checked against a built-in predictor
`timescale 1ns / 1ps

module tb_grid_dda_ray_caster;
  import gdrc_pkg::*;

  localparam int COLS = 32;
  localparam int ROWS = 32;
  localparam int STEP_LIMIT = 64;
  localparam int CELLS = COLS * ROWS;
  localparam int SETTLE = 600;
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CAST = 1'b1;

  typedef struct {
    logic               op;
    logic [9:0]         map_index;
    logic               wall_bit;
    logic [15:0]        pos_x;
    logic [15:0]        pos_y;
    logic [4:0]         start_col;
    logic [4:0]         start_row;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
  } ray_item_t;

  typedef struct {
    logic        hit;
    logic [4:0]  col;
    logic [4:0]  row;
    logic [19:0] distance;
    logic        x_side;
  } ray_hit_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // map_index, wall_bit, pos_x, pos_y, start_col, start_row, dir_x, dir_y, zero fill
  logic [87:0] s_tdata = '0;
  // op
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // hit, hit_col, hit_row, hit_distance, crossed_x_side
  logic [31:0] m_tdata;

  // predictor state
  bit        wall_bits [CELLS];
  bit [7:0]  cell_w = 8'd64;
  bit [7:0]  cell_h = 8'd64;

  ray_item_t send_q [$];
  ray_hit_t  hit_q [$];
  ray_item_t cur_item;
  int        gap_cnt = 0;
  int        burst_cnt = 0;
  int        fail_cnt = 0;
  int        cast_cnt = 0;
  int        wall_hit_cnt = 0;
  int        write_cnt = 0;
  int        stall_mode = 0;
  int        stall_tick = 0;

  grid_dda_ray_caster i_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #6 clk = ~clk;

  // integer square root, floor
  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  // pixel length k*|dir|/|component|, saturated
  function automatic int unsigned ray_len(int unsigned k, int unsigned a,
                                          longint unsigned m2);
    longint unsigned q;
    longint unsigned r;
    if (a == 0) return DIST_MAX;
    q = (longint'(k) * k * m2) / (longint'(a) * a);
    r = int_root(q);
    return (r > DIST_MAX) ? DIST_MAX : int'(r);
  endfunction

  function automatic int unsigned dist_add(int unsigned a, int unsigned b);
    return (a + b > DIST_MAX) ? DIST_MAX : a + b;
  endfunction

  // applies one item to the predictor, queues the expected hit of a cast
  task automatic predict_ray(input ray_item_t it);
    int unsigned ax, ay, sx, sy, dlx, dly, sdx, sdy;
    int unsigned lastx, lasty, steps;
    longint unsigned m2;
    bit negx, negy, anyx, anyy, stepx;
    int col, row, nc, nr;
    ray_hit_t res;
    if (it.op == OP_WRITE) begin
      write_cnt++;
      if (it.map_index < CELLS) wall_bits[it.map_index] = it.wall_bit;
      return;
    end
    cast_cnt++;
    res = '{hit: 1'b0, col: it.start_col, row: it.start_row, distance: '0, x_side: 1'b0};
    lastx = 0; lasty = 0; steps = 0; anyx = 0; anyy = 0;
    col = it.start_col;
    row = it.start_row;
    negx = it.dir_x < 0;
    negy = it.dir_y < 0;
    ax = negx ? -int'(it.dir_x) : int'(it.dir_x);
    ay = negy ? -int'(it.dir_y) : int'(it.dir_y);
    m2 = longint'(ax) * ax + longint'(ay) * ay;
    sx = negx ? it.pos_x % cell_w : cell_w - it.pos_x % cell_w;
    sy = negy ? it.pos_y % cell_h : cell_h - it.pos_y % cell_h;
    dlx = ray_len(cell_w, ax, m2);
    dly = ray_len(cell_h, ay, m2);
    sdx = ray_len(sx, ax, m2);
    sdy = ray_len(sy, ay, m2);
    if (col < COLS && row < ROWS) begin
      forever begin
        if (wall_bits[row * COLS + col]) begin
          res.hit = 1'b1;
          break;
        end
        if (steps >= STEP_LIMIT || (ax == 0 && ay == 0)) break;
        stepx = ax != 0 && (ay == 0 || sdx <= sdy);
        nc = col;
        nr = row;
        if (stepx) nc += negx ? -1 : 1;
        else nr += negy ? -1 : 1;
        if (nc < 0 || nc >= COLS || nr < 0 || nr >= ROWS) break;
        if (stepx) begin
          lastx = sdx; anyx = 1; sdx = dist_add(sdx, dlx);
        end else begin
          lasty = sdy; anyy = 1; sdy = dist_add(sdy, dly);
        end
        col = nc;
        row = nr;
        steps++;
      end
      if (anyx && (!anyy || lastx > lasty)) begin
        res.distance = 20'(lastx); res.x_side = 1'b1;
      end else if (anyy) begin
        res.distance = 20'(lasty);
      end
    end
    res.col = 5'(col);
    res.row = 5'(row);
    if (res.hit) wall_hit_cnt++;
    hit_q.push_back(res);
  endtask

  // sender: bursts and gaps, prediction at acceptance
  always @(posedge clk) begin : drive_items
    logic nv;
    nv = s_tvalid;
    if (rst) begin
      nv = 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_ray(cur_item);
        nv = 1'b0;
      end
      if (!nv) begin
        if (gap_cnt > 0) begin
          gap_cnt--;
        end else if (send_q.size() > 0) begin
          cur_item = send_q.pop_front();
          s_tuser <= cur_item.op;
          s_tdata <= {3'b000, cur_item.dir_y, cur_item.dir_x, cur_item.start_row,
                      cur_item.start_col, cur_item.pos_y, cur_item.pos_x,
                      cur_item.wall_bit, cur_item.map_index};
          nv = 1'b1;
          if (burst_cnt == 0) begin
            burst_cnt = $urandom_range(1, 12);
            gap_cnt = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
          end else begin
            burst_cnt--;
          end
        end
      end
    end
    s_tvalid <= nv;
  end

  // receiver: stall pattern redrawn periodically from four modes, checks against oldest expectation
  always @(posedge clk) begin : check_hits
    ray_hit_t want;
    ray_hit_t got;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = '{hit: m_tdata[0], col: m_tdata[5:1], row: m_tdata[10:6],
                distance: m_tdata[30:11], x_side: m_tdata[31]};
        if (hit_q.size() == 0) begin
          fail_cnt++;
          $display("%0t: unexpected result %h", $realtime, m_tdata);
        end else begin
          want = hit_q.pop_front();
          if (got.hit !== want.hit) begin
            fail_cnt++;
            $display("%0t: hit expected %0d actual %0d", $realtime, want.hit, got.hit);
          end
          if (got.col !== want.col) begin
            fail_cnt++;
            $display("%0t: hit_col expected %0d actual %0d", $realtime, want.col, got.col);
          end
          if (got.row !== want.row) begin
            fail_cnt++;
            $display("%0t: hit_row expected %0d actual %0d", $realtime, want.row, got.row);
          end
          if (got.distance !== want.distance) begin
            fail_cnt++;
            $display("%0t: hit_distance expected %0d actual %0d", $realtime,
                     want.distance, got.distance);
          end
          if (got.x_side !== want.x_side) begin
            fail_cnt++;
            $display("%0t: crossed_x_side expected %0d actual %0d", $realtime,
                     want.x_side, got.x_side);
          end
        end
      end
      stall_tick++;
      if (stall_tick % 64 == 0) stall_mode = $urandom_range(0, 3);
    end
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(0, 1));
      2: m_tready <= (stall_tick % 8) == 0;
      default: m_tready <= $urandom_range(0, 5) != 0;
    endcase
  end

  function automatic ray_item_t wall_item(int idx, bit wb);
    ray_item_t it;
    it = '{op: OP_WRITE, map_index: 10'(idx), wall_bit: wb, pos_x: 16'($urandom),
           pos_y: 16'($urandom), start_col: 5'($urandom), start_row: 5'($urandom),
           dir_x: 16'($urandom), dir_y: 16'($urandom)};
    return it;
  endfunction

  function automatic ray_item_t cast_item(int px, int py, int c, int r, int dx, int dy);
    ray_item_t it;
    it = '{op: OP_CAST, map_index: 10'($urandom), wall_bit: 1'($urandom), pos_x: 16'(px),
           pos_y: 16'(py), start_col: 5'(c), start_row: 5'(r), dir_x: 16'(dx),
           dir_y: 16'(dy)};
    return it;
  endfunction

  function automatic int rand_dir();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return $urandom_range(0, 1) ? 16384 : -16384;
      2: return $urandom_range(0, 1) ? 32767 : -32768;
      3: return int'($urandom_range(0, 64)) - 32;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  task automatic wait_drained();
    while (send_q.size() > 0 || s_tvalid || hit_q.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // register write with setup and access phases; the predictor follows at the access cycle
  task automatic reg_write(logic idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == REG_CELL_WIDTH) cell_w = (val[7:0] == 0) ? 8'd1 : val[7:0];
    else cell_h = (val[7:0] == 0) ? 8'd1 : val[7:0];
  endtask

  initial begin : run_phases
    logic [31:0] widths [6];
    logic [31:0] heights [6];
    widths = '{32'd64, 32'hABCD_5601, 32'h0000_00FF, 32'hFFFF_FF00, 32'h0000_0107, 32'd13};
    heights = '{32'd64, 32'h5432_A9FF, 32'h0000_0001, 32'd0, 32'h1234_56FF, 32'd40};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (!s_tready) @(posedge clk);

    // directed: empty map runs to the edges, extremes of direction and position
    send_q.push_back(cast_item(0, 0, 0, 0, 32767, 0));
    send_q.push_back(cast_item(65535, 65535, 31, 31, -32768, 0));
    send_q.push_back(cast_item(100, 65535, 5, 31, 0, -32768));
    send_q.push_back(cast_item(33, 90, 0, 0, 0, 32767));
    send_q.push_back(cast_item(10, 10, 0, 0, 16384, 16384));
    send_q.push_back(cast_item(2047, 2047, 31, 31, -11585, -11585));
    send_q.push_back(cast_item(500, 700, 7, 9, 0, 0));
    send_q.push_back(cast_item(63, 64, 0, 1, 1, 32767));
    send_q.push_back(cast_item(64, 63, 1, 0, -1, -32767));
    // walls: start cell on a wall, walls in every fourth cell of a row, zero direction on a wall
    send_q.push_back(wall_item(0, 1'b1));
    send_q.push_back(wall_item(1023, 1'b1));
    send_q.push_back(cast_item(5, 5, 0, 0, 0, 0));
    send_q.push_back(cast_item(2000, 2000, 31, 31, 0, 0));
    for (int c = 0; c < 32; c += 4) send_q.push_back(wall_item(20 * 32 + c, 1'b1));
    send_q.push_back(cast_item(300, 300, 4, 4, 3000, 32000));
    send_q.push_back(cast_item(300, 1900, 4, 29, -20000, -25000));
    send_q.push_back(wall_item(0, 1'b0));
    send_q.push_back(cast_item(5, 5, 0, 0, 0, 0));
    wait_drained();

    // each register setting gets random map writes and a set of casts
    for (int ph = 0; ph < 6; ph++) begin
      reg_write(REG_CELL_WIDTH, widths[ph]);
      reg_write(REG_CELL_HEIGHT, heights[ph]);
      for (int n = 0; n < 70; n++) begin
        if ($urandom_range(0, 4) == 0)
          send_q.push_back(wall_item($urandom_range(0, 1023), $urandom_range(0, 9) < 3));
        else
          send_q.push_back(cast_item($urandom_range(0, 65535), $urandom_range(0, 65535),
                                     $urandom_range(0, 31), $urandom_range(0, 31),
                                     rand_dir(), rand_dir()));
      end
      wait_drained();
    end

    $display("covered %0d casts (%0d wall hits) and %0d map writes over 6 register settings",
             cast_cnt, wall_hit_cnt, write_cnt);
    if (fail_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", fail_cnt);
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #20000000;
    $display("timeout with %0d results outstanding", hit_q.size());
    $display("status: fail");
    $finish;
  end

endmodule
